/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk with rst as disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* hdl/bfp8u_pkg.sv */
// ----------------------------------------------------------------------------
// bfp8u_pkg
// shared types and constants of the bfp8 tile unpacker
// ----------------------------------------------------------------------------
`default_nettype none

package bfp8u_pkg;

  // default tile shape
  localparam int TILE_ROWS_DEF = 32;
  localparam int TILE_COLS_DEF = 32;
  localparam int FACE_ROWS_DEF = 16;
  localparam int FACE_COLS_DEF = 16;
  localparam int EXP_WORDS_DEF = 16;

  // fixed field widths
  localparam int WORD_W      = 32;
  localparam int IDX_W       = 10;
  localparam int LANES       = 4;
  localparam int DATUM_W     = 8;
  localparam int MAN_W       = 7;
  localparam int EXPB_W      = 8;
  localparam int EFIELD_W    = 9;
  localparam int STORE_DEPTH = 16;
  localparam int STORE_SEL_W = 4;
  localparam int BYTE_SEL_W  = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 1;

  localparam logic [EFIELD_W-1:0] REBIAS_ADD = 9'd112;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REBIAS    = 1'b0,
    REG_ROW_MAJOR = 1'b1
  } cfg_reg_t;

  // decode of the current stream position
  typedef struct packed {
    logic                   is_data;
    logic                   last;
    logic                   exp_wr;
    logic [STORE_SEL_W-1:0] wr_sel;
    logic [STORE_SEL_W-1:0] exp_sel;
    logic [BYTE_SEL_W-1:0]  byte_sel;
    logic [IDX_W-1:0]       idx;
  } seq_info_t;

endpackage

`default_nettype wire

/* hdl/bfp8u_lane.sv */
// ----------------------------------------------------------------------------
// bfp8u_lane
// one datum: sign plus 7-bit mantissa and shared exponent to an fp32 pattern
// ----------------------------------------------------------------------------
`default_nettype none

module bfp8u_lane (
  input  wire logic [bfp8u_pkg::DATUM_W-1:0] datum,
  input  wire logic [bfp8u_pkg::EXPB_W-1:0]  expb,
  input  wire logic                          rebias,
  output logic      [bfp8u_pkg::WORD_W-1:0]  fp
);
  import bfp8u_pkg::*;

  logic             sign;
  logic [MAN_W-1:0] man;
  logic [MAN_W-1:0] man_norm;
  logic [2:0]       shift;
  logic [EFIELD_W-1:0] efield;
  logic             under;

  assign sign = datum[DATUM_W-1];
  assign man  = datum[MAN_W-1:0];

  // leading-one search, highest set bit wins
  always_comb begin
    shift = 3'd0;
    for (int i = 0; i < MAN_W; i++) begin
      if (man[i]) begin
        shift = 3'(MAN_W - 1 - i);
      end
    end
  end

  assign man_norm = man << shift;
  assign under    = {5'b0, shift} > expb;
  assign efield   = EFIELD_W'(expb) - EFIELD_W'(shift) + (rebias ? REBIAS_ADD : '0);

  always_comb begin
    if (man == '0) begin
      fp = {sign, 31'b0};
    end else if (under) begin
      fp = '0;
    end else begin
      // bit 8 of the exponent field lands on bit 31 together with the sign
      fp = {sign | efield[8], efield[7:0], man_norm[5:0], 1'b0, 16'b0};
    end
  end

endmodule

`default_nettype wire

/* hdl/bfp8u_seq.sv */
// ----------------------------------------------------------------------------
// bfp8u_seq
// position within the tile, exponent select and element index tracking
// ----------------------------------------------------------------------------
`default_nettype none

module bfp8u_seq #(
  parameter int TILE_ROWS = bfp8u_pkg::TILE_ROWS_DEF,
  parameter int TILE_COLS = bfp8u_pkg::TILE_COLS_DEF,
  parameter int FACE_ROWS = bfp8u_pkg::FACE_ROWS_DEF,
  parameter int FACE_COLS = bfp8u_pkg::FACE_COLS_DEF,
  parameter int EXP_WORDS = bfp8u_pkg::EXP_WORDS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  advance,
  input  wire logic                  row_major,
  output bfp8u_pkg::seq_info_t       info
);
  import bfp8u_pkg::*;

  localparam int TOTAL_WORDS = EXP_WORDS + (TILE_ROWS * TILE_COLS) / LANES;
  localparam int POS_W       = $clog2(TOTAL_WORDS);
  localparam int FPR         = TILE_COLS / FACE_COLS;
  localparam int C_W         = $clog2(FACE_COLS);
  localparam int R_W         = (FACE_ROWS > 1) ? $clog2(FACE_ROWS) : 1;
  localparam int TC_W        = (FPR > 1) ? $clog2(FPR) : 1;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [C_W-1:0]   col;
  logic [R_W-1:0]   row;
  logic [TC_W-1:0]  face_col;
  logic [IDX_W-1:0] face_row;
  logic [C_W:0]     col_sum;
  logic [7:0]       dword;
  logic [IDX_W-1:0] row_base;
  logic [IDX_W-1:0] rm_idx;
  logic             is_data;
  logic             last;

  assign is_data  = pos >= POS_W'(EXP_WORDS);
  assign last     = pos == POS_W'(TOTAL_WORDS - 1);
  assign pos_next = last ? '0 : pos + 1'b1;
  assign dword    = 8'(pos - POS_W'(EXP_WORDS));
  assign col_sum  = (C_W + 1)'(col) + (C_W + 1)'(LANES);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      col      <= '0;
      row      <= '0;
      face_col <= '0;
      face_row <= '0;
    end else if (advance) begin
      pos <= pos_next;
      if (!is_data || last) begin
        col      <= '0;
        row      <= '0;
        face_col <= '0;
        face_row <= '0;
      end else if (col_sum >= (C_W + 1)'(FACE_COLS)) begin
        col <= C_W'(col_sum - (C_W + 1)'(FACE_COLS));
        if (row == R_W'(FACE_ROWS - 1)) begin
          row <= '0;
          if (face_col == TC_W'(FPR - 1)) begin
            face_col <= '0;
            face_row <= face_row + 1'b1;
          end else begin
            face_col <= face_col + 1'b1;
          end
        end else begin
          row <= row + 1'b1;
        end
      end else begin
        col <= C_W'(col_sum);
      end
    end
  end

  // row-major index, wrapped to the index width
  assign row_base = IDX_W'(face_row * FACE_ROWS) + IDX_W'(row);
  assign rm_idx   = IDX_W'(row_base * TILE_COLS) + IDX_W'(face_col * FACE_COLS)
                  + IDX_W'(col);

  always_comb begin
    info.is_data  = is_data;
    info.last     = last;
    info.exp_wr   = !is_data && (pos < POS_W'(STORE_DEPTH));
    info.wr_sel   = STORE_SEL_W'(pos);
    info.exp_sel  = dword[7:4];
    info.byte_sel = dword[3:2];
    info.idx      = row_major ? rm_idx : IDX_W'({dword, 2'b00});
  end

endmodule

`default_nettype wire

/* hdl/bfp8_tile_unpacker.sv */
// ----------------------------------------------------------------------------
// bfp8_tile_unpacker
// unpacks a bfp8 tile stream (shared exponents, then 4 datums per word) to fp32
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               payload
//  in       sink       in_valid / in_ready     tile_word
//  out      source     out_valid / out_ready   float_lane0..3, element_index,
//                                              last_of_tile
//  cfg      sink       cfg_we                  cfg_index, cfg_data
//
//  one item per cycle; a data word shows its result in the cycle after it is taken,
//  decoded by four lanes in parallel and held in the output register
//  exponent words are taken at the same rate and give no result
//  rst clears position, index counters, configuration registers and output valid;
//  the exponent store is not cleared
//  a stalled output takes new items only as the output register drains
//
`default_nettype none

`include "assert_macros.svh"

module bfp8_tile_unpacker #(
  parameter int TILE_ROWS = bfp8u_pkg::TILE_ROWS_DEF,
  parameter int TILE_COLS = bfp8u_pkg::TILE_COLS_DEF,
  parameter int FACE_ROWS = bfp8u_pkg::FACE_ROWS_DEF,
  parameter int FACE_COLS = bfp8u_pkg::FACE_COLS_DEF,
  parameter int EXP_WORDS = bfp8u_pkg::EXP_WORDS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [bfp8u_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bfp8u_pkg::CFG_DATA_W-1:0]  cfg_data,
  // word stream in
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [bfp8u_pkg::WORD_W-1:0]      tile_word,
  // fp32 results out
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [bfp8u_pkg::WORD_W-1:0]      float_lane0,
  output logic      [bfp8u_pkg::WORD_W-1:0]      float_lane1,
  output logic      [bfp8u_pkg::WORD_W-1:0]      float_lane2,
  output logic      [bfp8u_pkg::WORD_W-1:0]      float_lane3,
  output logic      [bfp8u_pkg::IDX_W-1:0]       element_index,
  output logic                                   last_of_tile
);
  import bfp8u_pkg::*;

  logic                 rebias_mode;
  logic                 row_major_order;
  logic                 in_acc;
  logic                 out_valid_next;
  seq_info_t            info;
  logic [WORD_W-1:0]    exp_store [STORE_DEPTH];
  logic [WORD_W-1:0]    store_word;
  logic [EXPB_W-1:0]    expb;
  logic [WORD_W-1:0]    lane_fp [LANES];

  // configuration registers, only bit 0 of the data is kept
  always_ff @(posedge clk) begin
    if (rst) begin
      rebias_mode     <= 1'b0;
      row_major_order <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REBIAS:    rebias_mode     <= cfg_data[0];
        REG_ROW_MAJOR: row_major_order <= cfg_data[0];
      endcase
    end
  end

  // the output register frees up in the same cycle it is taken
  assign in_ready = !out_valid || out_ready;
  assign in_acc   = in_valid && in_ready;

  // tile position, exponent select and element index
  bfp8u_seq #(
    .TILE_ROWS (TILE_ROWS),
    .TILE_COLS (TILE_COLS),
    .FACE_ROWS (FACE_ROWS),
    .FACE_COLS (FACE_COLS),
    .EXP_WORDS (EXP_WORDS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .advance   (in_acc),
    .row_major (row_major_order),
    .info      (info)
  );

  // shared exponent store: written by exponent words, no reset
  // exponent words beyond the store depth are taken and dropped
  always_ff @(posedge clk) begin
    if (in_acc && info.exp_wr) begin
      exp_store[info.wr_sel] <= tile_word;
    end
  end

  // one exponent byte covers sixteen datums, i.e. four data words
  assign store_word = exp_store[info.exp_sel];
  assign expb       = store_word[info.byte_sel * EXPB_W +: EXPB_W];

  // four decode lanes, one per datum byte of the word
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bfp8u_lane u_lane (
      .datum  (tile_word[g * DATUM_W +: DATUM_W]),
      .expb   (expb),
      .rebias (rebias_mode),
      .fp     (lane_fp[g])
    );
  end

  // merge stage: lanes, index and tile end land in one output register
  always_comb begin
    if (in_acc && info.is_data) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && info.is_data) begin
      float_lane0   <= lane_fp[0];
      float_lane1   <= lane_fp[1];
      float_lane2   <= lane_fp[2];
      float_lane3   <= lane_fp[3];
      element_index <= info.idx;
      last_of_tile  <= info.last;
    end
  end

  // ---- assertions ----
  `ASSERT_CLK(a_data_gives_result, (in_acc && info.is_data) |=> out_valid, "data item lost")
  `ASSERT_CLK(a_exp_gives_none, (in_acc && !info.is_data && !out_valid) |=> !out_valid, "exponent item made a result")
  `ASSERT_CLK(a_tile_restarts, (in_acc && info.last) |=> !info.is_data, "tile did not restart on exponents")
  `ASSERT_NEVER(a_empty_not_ready, !out_valid && !in_ready, "stalled with empty output")

endmodule

`default_nettype wire
